>>> rtl/atc_pkg.sv
package atc_pkg;

  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // shared unit widths: 33x33 signed multiply, wide accumulator for the
  // partial-product chain of the adaptation step
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int KPROD_W = GAIN_W + DATA_W;
  localparam int YR_W    = 2 * DATA_W;

  localparam logic [GAIN_W-1:0] ERROR_WEIGHT_RST  = 31'd327680;   // 5.0
  localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = 31'd655360;   // 10.0
  localparam logic [GAIN_W-1:0] RATE_RST          = 31'd131072;   // 2.0
  localparam logic [DATA_W-1:0] TIME_STEP_RST     = 32'd4294967;  // ~1 ms
  localparam logic signed [DATA_W-1:0] ONE_Q16    = 32'sd65536;   // 1.0

  localparam logic [CFG_IDX_W-1:0] REG_ERROR_WEIGHT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd5;

  typedef enum logic [1:0] {
    BASE_ZERO    = 2'd0,
    BASE_ACC     = 2'd1,
    BASE_ACC_SHR = 2'd2,
    BASE_OPA     = 2'd3
  } base_sel_t;

  typedef enum logic [1:0] {
    ADD_PROD   = 2'd0,
    ADD_PROD_Q = 2'd1,
    ADD_OPB    = 2'd2
  } addend_sel_t;

  typedef struct packed {
    logic        acc_en;
    base_sel_t   base;
    addend_sel_t addend;
    logic        sub;
  } alu_ctl_t;

endpackage

>>> rtl/atc_if.sv
interface atc_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [atc_pkg::DATA_W-1:0]    position;
  logic signed [atc_pkg::DATA_W-1:0]    velocity;
  logic signed [atc_pkg::DATA_W-1:0]    target_position;
  logic signed [atc_pkg::DATA_W-1:0]    target_velocity;
  logic signed [atc_pkg::DATA_W-1:0]    target_accel;

  modport source (
    output valid, position, velocity, target_position, target_velocity, target_accel,
    input  ready
  );
  modport sink (
    input  valid, position, velocity, target_position, target_velocity, target_accel,
    output ready
  );
endinterface

interface atc_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [atc_pkg::DATA_W-1:0]    drive;
  logic signed [atc_pkg::DATA_W-1:0]    filtered_error;
  logic signed [atc_pkg::DATA_W-1:0]    mass_out;
  logic signed [atc_pkg::DATA_W-1:0]    damping_out;
  logic signed [atc_pkg::DATA_W-1:0]    offset_out;
  logic                                 saturated;

  modport source (
    output valid, drive, filtered_error, mass_out, damping_out, offset_out, saturated,
    input  ready
  );
  modport sink (
    input  valid, drive, filtered_error, mass_out, damping_out, offset_out, saturated,
    output ready
  );
endinterface

>>> rtl/adaptive_tracking_controller_unit.sv
// Channel   Role     Handshake      Payload
// sample    sink     valid/ready    position, velocity, target_position,
//                                   target_velocity, target_accel
// result    source   valid/ready    drive, filtered_error, mass_out,
//                                   damping_out, offset_out, saturated
// write     config   write_enable   write_index, write_data
//
// A transaction runs from acceptance to the next possible acceptance through
// 13 sequencer steps for the errors and the drive and 9 per estimate for the
// three updates, all through one shared 33x33 multiplier and one 68-bit
// accumulator. Reset is synchronous; it restores the gains and clears the
// estimates. The finished result sits in an output register, so a stalled
// result only holds the sequencer at its last step.
module adaptive_tracking_controller_unit import atc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [CFG_IDX_W-1:0]  write_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  atc_sample_if.sink            sample,
  atc_result_if.source          result
);

  typedef enum logic [23:0] {
    S_IDLE    = 24'h000001,
    S_E       = 24'h000002,
    S_EDOT    = 24'h000004,
    S_AE_MUL  = 24'h000008,
    S_AED_MUL = 24'h000010,
    S_AE_WB   = 24'h000020,
    S_AED_WB  = 24'h000040,
    S_R_WB    = 24'h000080,
    S_XRD_WB  = 24'h000100,
    S_XRDD_WB = 24'h000200,
    S_U_M1    = 24'h000400,
    S_U_M2    = 24'h000800,
    S_U_ACC   = 24'h001000,
    S_U_WB    = 24'h002000,
    S_A_K     = 24'h004000,
    S_A_YR    = 24'h008000,
    S_A_P00   = 24'h010000,
    S_A_P01   = 24'h020000,
    S_A_P10   = 24'h040000,
    S_A_P11   = 24'h080000,
    S_A_SUM   = 24'h100000,
    S_A_EST   = 24'h200000,
    S_A_WB    = 24'h400000,
    S_DONE    = 24'h800000
  } state_t;

  localparam logic [1:0] EST_MASS    = 2'd0;
  localparam logic [1:0] EST_DAMPING = 2'd1;
  localparam logic [1:0] EST_OFFSET  = 2'd2;

  state_t state;
  state_t state_next;

  logic [GAIN_W-1:0] error_weight;
  logic [GAIN_W-1:0] feedback_gain;
  logic [GAIN_W-1:0] mass_rate;
  logic [GAIN_W-1:0] damping_rate;
  logic [GAIN_W-1:0] offset_rate;
  logic [DATA_W-1:0] time_step;

  logic signed [DATA_W-1:0] mass_est;
  logic signed [DATA_W-1:0] damping_est;
  logic signed [DATA_W-1:0] offset_est;

  logic signed [DATA_W-1:0] pos;
  logic signed [DATA_W-1:0] vel;
  logic signed [DATA_W-1:0] tpos;
  logic signed [DATA_W-1:0] tvel;
  logic signed [DATA_W-1:0] tacc;

  logic signed [DATA_W-1:0] e;
  logic signed [DATA_W-1:0] edot;
  logic signed [DATA_W-1:0] ae;
  logic signed [DATA_W-1:0] aed;
  logic signed [DATA_W-1:0] r;
  logic signed [DATA_W-1:0] xrd;
  logic signed [DATA_W-1:0] xrdd;
  logic signed [DATA_W-1:0] drive_r;
  logic [KPROD_W-1:0]       k;
  logic signed [YR_W-1:0]   yr;
  logic [1:0]               idx;
  logic                     clip;

  alu_ctl_t                 ctl;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [DATA_W-1:0] opa;
  logic signed [DATA_W-1:0] opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic signed [DATA_W-1:0] acc_sat;
  logic                     acc_clip;
  logic [GAIN_W-1:0]        rate_sel;
  logic signed [DATA_W-1:0] y_sel;
  logic signed [DATA_W-1:0] est_sel;

  atc_alu u_alu (
    .clk   (clk),
    .ctl   (ctl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .opa   (opa),
    .opb   (opb),
    .prod  (prod),
    .acc   (acc)
  );

  // clip the accumulator to signed 32 bits
  assign acc_clip = ~((&acc[ACC_W-1:DATA_W-1]) | ~(|acc[ACC_W-1:DATA_W-1]));
  always_comb begin
    if (!acc_clip) begin
      acc_sat = acc[DATA_W-1:0];
    end else if (acc[ACC_W-1]) begin
      acc_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_comb begin
    case (idx)
      EST_MASS: begin
        rate_sel = mass_rate;
        y_sel    = xrdd;
        est_sel  = mass_est;
      end
      EST_DAMPING: begin
        rate_sel = damping_rate;
        y_sel    = xrd;
        est_sel  = damping_est;
      end
      default: begin
        rate_sel = offset_rate;
        y_sel    = ONE_Q16;
        est_sel  = offset_est;
      end
    endcase
  end

  assign sample.ready = (state == S_IDLE);

  always_comb begin
    ctl        = '{acc_en: 1'b0, base: BASE_ZERO, addend: ADD_PROD, sub: 1'b0};
    mul_a      = '0;
    mul_b      = '0;
    opa        = '0;
    opb        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample.valid) begin
          state_next = S_E;
        end
      end
      S_E: begin
        ctl        = '{acc_en: 1'b1, base: BASE_OPA, addend: ADD_OPB, sub: 1'b1};
        opa        = tpos;
        opb        = pos;
        state_next = S_EDOT;
      end
      S_EDOT: begin
        ctl        = '{acc_en: 1'b1, base: BASE_OPA, addend: ADD_OPB, sub: 1'b1};
        opa        = tvel;
        opb        = vel;
        state_next = S_AE_MUL;
      end
      S_AE_MUL: begin
        mul_a      = {2'b00, error_weight};
        mul_b      = {e[DATA_W-1], e};
        state_next = S_AED_MUL;
      end
      S_AED_MUL: begin
        mul_a      = {2'b00, error_weight};
        mul_b      = {edot[DATA_W-1], edot};
        ctl        = '{acc_en: 1'b1, base: BASE_ZERO, addend: ADD_PROD_Q, sub: 1'b0};
        state_next = S_AE_WB;
      end
      S_AE_WB: begin
        ctl        = '{acc_en: 1'b1, base: BASE_ZERO, addend: ADD_PROD_Q, sub: 1'b0};
        state_next = S_AED_WB;
      end
      S_AED_WB: begin
        ctl        = '{acc_en: 1'b1, base: BASE_OPA, addend: ADD_OPB, sub: 1'b0};
        opa        = edot;
        opb        = ae;
        state_next = S_R_WB;
      end
      S_R_WB: begin
        ctl        = '{acc_en: 1'b1, base: BASE_OPA, addend: ADD_OPB, sub: 1'b0};
        opa        = tvel;
        opb        = ae;
        state_next = S_XRD_WB;
      end
      S_XRD_WB: begin
        ctl        = '{acc_en: 1'b1, base: BASE_OPA, addend: ADD_OPB, sub: 1'b0};
        opa        = tacc;
        opb        = aed;
        state_next = S_XRDD_WB;
      end
      S_XRDD_WB: begin
        mul_a      = {2'b00, feedback_gain};
        mul_b      = {r[DATA_W-1], r};
        state_next = S_U_M1;
      end
      S_U_M1: begin
        mul_a      = {xrdd[DATA_W-1], xrdd};
        mul_b      = {mass_est[DATA_W-1], mass_est};
        ctl        = '{acc_en: 1'b1, base: BASE_OPA, addend: ADD_PROD_Q, sub: 1'b0};
        opa        = offset_est;
        state_next = S_U_M2;
      end
      S_U_M2: begin
        mul_a      = {xrd[DATA_W-1], xrd};
        mul_b      = {damping_est[DATA_W-1], damping_est};
        ctl        = '{acc_en: 1'b1, base: BASE_ACC, addend: ADD_PROD_Q, sub: 1'b0};
        state_next = S_U_ACC;
      end
      S_U_ACC: begin
        ctl        = '{acc_en: 1'b1, base: BASE_ACC, addend: ADD_PROD_Q, sub: 1'b0};
        state_next = S_U_WB;
      end
      S_U_WB: begin
        state_next = S_A_K;
      end
      S_A_K: begin
        mul_a      = {2'b00, rate_sel};
        mul_b      = {1'b0, time_step};
        state_next = S_A_YR;
      end
      S_A_YR: begin
        mul_a      = {y_sel[DATA_W-1], y_sel};
        mul_b      = {r[DATA_W-1], r};
        state_next = S_A_P00;
      end
      S_A_P00: begin
        // the regressor product is still in the product register
        mul_a      = {1'b0, prod[DATA_W-1:0]};
        mul_b      = {1'b0, k[DATA_W-1:0]};
        state_next = S_A_P01;
      end
      S_A_P01: begin
        mul_a      = {yr[YR_W-1], yr[YR_W-1:DATA_W]};
        mul_b      = {1'b0, k[DATA_W-1:0]};
        ctl        = '{acc_en: 1'b1, base: BASE_ZERO, addend: ADD_PROD, sub: 1'b0};
        state_next = S_A_P10;
      end
      S_A_P10: begin
        mul_a      = {1'b0, yr[DATA_W-1:0]};
        mul_b      = {2'b00, k[KPROD_W-1:DATA_W]};
        ctl        = '{acc_en: 1'b1, base: BASE_ACC_SHR, addend: ADD_PROD, sub: 1'b0};
        state_next = S_A_P11;
      end
      S_A_P11: begin
        mul_a      = {yr[YR_W-1], yr[YR_W-1:DATA_W]};
        mul_b      = {2'b00, k[KPROD_W-1:DATA_W]};
        ctl        = '{acc_en: 1'b1, base: BASE_ACC, addend: ADD_PROD, sub: 1'b0};
        state_next = S_A_SUM;
      end
      S_A_SUM: begin
        // dropping the low words stepwise keeps the overall floor exact
        ctl        = '{acc_en: 1'b1, base: BASE_ACC_SHR, addend: ADD_PROD, sub: 1'b0};
        state_next = S_A_EST;
      end
      S_A_EST: begin
        ctl        = '{acc_en: 1'b1, base: BASE_ACC, addend: ADD_OPB, sub: 1'b0};
        opb        = est_sel;
        state_next = S_A_WB;
      end
      S_A_WB: begin
        state_next = (idx == EST_OFFSET) ? S_DONE : S_A_K;
      end
      S_DONE: begin
        if (!result.valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      error_weight  <= ERROR_WEIGHT_RST;
      feedback_gain <= FEEDBACK_GAIN_RST;
      mass_rate     <= RATE_RST;
      damping_rate  <= RATE_RST;
      offset_rate   <= RATE_RST;
      time_step     <= TIME_STEP_RST;
      mass_est      <= '0;
      damping_est   <= '0;
      offset_est    <= '0;
      idx           <= EST_MASS;
      clip          <= 1'b0;
      result.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (write_enable) begin
        unique case (write_index)
          REG_ERROR_WEIGHT:  error_weight  <= write_data[GAIN_W-1:0];
          REG_FEEDBACK_GAIN: feedback_gain <= write_data[GAIN_W-1:0];
          REG_MASS_RATE:     mass_rate     <= write_data[GAIN_W-1:0];
          REG_DAMPING_RATE:  damping_rate  <= write_data[GAIN_W-1:0];
          REG_OFFSET_RATE:   offset_rate   <= write_data[GAIN_W-1:0];
          REG_TIME_STEP:     time_step     <= write_data[DATA_W-1:0];
          default: ;
        endcase
      end

      // load a finished transaction, or drop the one just taken
      if (state == S_DONE && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end

      unique case (state) inside
        S_IDLE: begin
          if (sample.valid) begin
            clip <= 1'b0;
          end
        end
        S_EDOT, S_AE_MUL, S_AE_WB, S_AED_WB, S_R_WB, S_XRD_WB, S_XRDD_WB, S_U_WB: begin
          clip <= clip | acc_clip;
          idx  <= EST_MASS;
        end
        S_A_WB: begin
          clip <= clip | acc_clip;
          idx  <= idx + 2'd1;
          case (idx)
            EST_MASS:    mass_est    <= acc_sat;
            EST_DAMPING: damping_est <= acc_sat;
            default:     offset_est  <= acc_sat;
          endcase
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (sample.valid) begin
          pos  <= sample.position;
          vel  <= sample.velocity;
          tpos <= sample.target_position;
          tvel <= sample.target_velocity;
          tacc <= sample.target_accel;
        end
      end
      S_EDOT:    e       <= acc_sat;
      S_AE_MUL:  edot    <= acc_sat;
      S_AE_WB:   ae      <= acc_sat;
      S_AED_WB:  aed     <= acc_sat;
      S_R_WB:    r       <= acc_sat;
      S_XRD_WB:  xrd     <= acc_sat;
      S_XRDD_WB: xrdd    <= acc_sat;
      S_U_WB:    drive_r <= acc_sat;
      S_A_YR:    k       <= prod[KPROD_W-1:0];
      S_A_P00:   yr      <= prod[YR_W-1:0];
      S_DONE: begin
        if (!result.valid || result.ready) begin
          result.drive          <= drive_r;
          result.filtered_error <= r;
          result.mass_out       <= mass_est;
          result.damping_out    <= damping_est;
          result.offset_out     <= offset_est;
          result.saturated      <= clip;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/atc_alu.sv
module atc_alu import atc_pkg::*; (
  input  logic                     clk,
  input  alu_ctl_t                 ctl,
  input  logic signed [MUL_W-1:0]  mul_a,
  input  logic signed [MUL_W-1:0]  mul_b,
  input  logic signed [DATA_W-1:0] opa,
  input  logic signed [DATA_W-1:0] opb,
  output logic signed [PROD_W-1:0] prod,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [ACC_W-1:0] prod_x;
  logic signed [ACC_W-1:0] opa_x;
  logic signed [ACC_W-1:0] opb_x;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] acc_next;

  assign prod_x = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign opa_x  = {{(ACC_W-DATA_W){opa[DATA_W-1]}}, opa};
  assign opb_x  = {{(ACC_W-DATA_W){opb[DATA_W-1]}}, opb};

  always_comb begin
    unique case (ctl.base)
      BASE_ZERO:    base = '0;
      BASE_ACC:     base = acc;
      BASE_ACC_SHR: base = acc >>> DATA_W;
      BASE_OPA:     base = opa_x;
      default:      base = '0;
    endcase
    unique case (ctl.addend)
      ADD_PROD:   addend = prod_x;
      ADD_PROD_Q: addend = prod_x >>> (DATA_W / 2);   // floor of a Q16.16 product
      ADD_OPB:    addend = opb_x;
      default:    addend = '0;
    endcase
    // subtract as add of the complement with carry in
    acc_next = base + (ctl.sub ? ~addend : addend) + ACC_W'(ctl.sub);
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctl.acc_en) begin
      acc <= acc_next;
    end
  end

endmodule

>>> rtl/atc_checker.sv
module atc_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] result_drive,
  input logic [31:0] result_filtered_error
);

  // the block comes out of reset able to take a transaction
  assert property (@(posedge clk) rst |=> sample_ready)
    else $error("sample not ready after reset");

  // an accepted transaction keeps the sequencer busy
  assert property (@(posedge clk) !rst && sample_valid && sample_ready |=> !sample_ready)
    else $error("sample ready right after acceptance");

  assert property (@(posedge clk) !rst && result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk)
    !rst && result_valid && !result_ready |=>
      $stable(result_drive) && $stable(result_filtered_error))
    else $error("result payload changed while stalled");

endmodule

bind adaptive_tracking_controller_unit atc_checker u_atc_checker (
  .clk                   (clk),
  .rst                   (rst),
  .sample_valid          (sample.valid),
  .sample_ready          (sample.ready),
  .result_valid          (result.valid),
  .result_ready          (result.ready),
  .result_drive          (result.drive),
  .result_filtered_error (result.filtered_error)
);

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import atc_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] target_position;
    logic signed [DATA_W-1:0] target_velocity;
    logic signed [DATA_W-1:0] target_accel;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] filtered_error;
    logic signed [DATA_W-1:0] mass_out;
    logic signed [DATA_W-1:0] damping_out;
    logic signed [DATA_W-1:0] offset_out;
    logic                     saturated;
  } tick_t;

  typedef struct packed {
    sample_t s;
    logic    typed;
    tick_t   want;
  } row_t;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  localparam logic [DATA_W-1:0] W_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] W_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] W_ZERO = 32'h0000_0000;
  localparam logic [DATA_W-1:0] W_ONE  = 32'h0001_0000;
  localparam tick_t ZERO_TICK = '0;

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] WRITE_ORDER [8] = '{
    REG_ERROR_WEIGHT, REG_FEEDBACK_GAIN, REG_MASS_RATE, REG_DAMPING_RATE,
    REG_OFFSET_RATE, REG_TIME_STEP, UNMAPPED_LO, UNMAPPED_HI
  };

  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 119;
  localparam int LONG_STALL       = 400;
  localparam int DRAIN_CYCLES     = 60;

  logic                  clk;
  logic                  rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  write_index;
  logic [CFG_DATA_W-1:0] write_data;

  atc_sample_if sample_ch ();
  atc_result_if result_ch ();

  adaptive_tracking_controller_unit dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .sample       (sample_ch),
    .result       (result_ch)
  );

  // controller copy: gains, tick length and the three estimates
  logic [GAIN_W-1:0] alpha_q  = ERROR_WEIGHT_RST;
  logic [GAIN_W-1:0] gain_k   = FEEDBACK_GAIN_RST;
  logic [GAIN_W-1:0] rate_m   = RATE_RST;
  logic [GAIN_W-1:0] rate_c   = RATE_RST;
  logic [GAIN_W-1:0] rate_d   = RATE_RST;
  logic [DATA_W-1:0] dt_q     = TIME_STEP_RST;
  longint            m_hat    = 0;
  longint            c_hat    = 0;
  longint            d_hat    = 0;
  logic              clip_seen;

  tick_t             expected_ticks [$];
  logic [CFG_DATA_W-1:0] pending_cfg [8];
  int                mismatches = 0;
  int                ticks_seen = 0;
  bit                gaps_on = 1'b1;
  bit                stall_request = 1'b0;

  row_t directed_rows [20] = '{
    '{{W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO}, 1'b1, ZERO_TICK},
    '{{W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_MAX}, 1'b1, ZERO_TICK},
    '{{W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_MIN}, 1'b1, ZERO_TICK},
    '{{W_MIN, W_ZERO, W_MAX, W_ZERO, W_ZERO}, 1'b0, ZERO_TICK},
    '{{W_MAX, W_ZERO, W_MIN, W_ZERO, W_ZERO}, 1'b0, ZERO_TICK},
    '{{W_ZERO, W_MIN, W_ZERO, W_MAX, W_ZERO}, 1'b0, ZERO_TICK},
    '{{W_ZERO, W_MAX, W_ZERO, W_MIN, W_ZERO}, 1'b0, ZERO_TICK},
    '{{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX}, 1'b0, ZERO_TICK},
    '{{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN}, 1'b0, ZERO_TICK},
    '{{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b0, ZERO_TICK},
    '{{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
      1'b0, ZERO_TICK},
    '{{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
      1'b0, ZERO_TICK},
    '{{W_ONE, W_ZERO, W_ZERO, W_ZERO, W_ZERO}, 1'b0, ZERO_TICK},
    '{{32'hFFFF_0000, W_ZERO, W_ZERO, W_ZERO, W_ZERO}, 1'b0, ZERO_TICK},
    '{{W_ZERO, W_ZERO, 32'h0000_0001, W_ZERO, W_ZERO}, 1'b0, ZERO_TICK},
    '{{W_ZERO, W_ZERO, 32'hFFFF_FFFF, W_ZERO, W_ZERO}, 1'b0, ZERO_TICK},
    '{{32'h0001_8000, 32'h0000_8000, 32'h0002_0000, W_ONE, 32'hFFFF_0000},
      1'b0, ZERO_TICK},
    '{{W_ZERO, 32'hFFFE_0000, W_ZERO, 32'h0002_0000, 32'h0010_0000}, 1'b0, ZERO_TICK},
    '{{W_ZERO, W_MAX, 32'h0010_0000, W_MAX, W_ZERO}, 1'b0, ZERO_TICK},
    '{{W_ZERO, 32'h0010_0000, W_ZERO, W_ZERO, W_MIN}, 1'b0, ZERO_TICK}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp32(input longint x);
    if (x > SAT_HI) begin
      clip_seen = 1'b1;
      return SAT_HI;
    end
    if (x < SAT_LO) begin
      clip_seen = 1'b1;
      return SAT_LO;
    end
    return x;
  endfunction

  // Q16.16 product, floored
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  // gradient step: est + floor(y*r*rate*dt / 2^64), saturated
  function automatic longint adapt(input longint est, input longint y, input longint r,
                                   input logic [GAIN_W-1:0] rate);
    logic [63:0]         k;
    logic signed [129:0] yr_w;
    logic signed [129:0] k_w;
    logic signed [129:0] prod;
    longint              delta;
    k     = 64'(rate) * 64'(dt_q);
    yr_w  = y * r;
    k_w   = {66'd0, k};
    prod  = yr_w * k_w;
    delta = longint'(prod >>> 64);
    return clamp32(est + delta);
  endfunction

  function automatic tick_t control_step(input sample_t s);
    longint e, ed, ae, aed, r, xrd, xrdd, u;
    tick_t  t;
    clip_seen = 1'b0;
    e    = clamp32(longint'($signed(s.target_position)) - longint'($signed(s.position)));
    ed   = clamp32(longint'($signed(s.target_velocity)) - longint'($signed(s.velocity)));
    ae   = clamp32(qmul(longint'(alpha_q), e));
    aed  = clamp32(qmul(longint'(alpha_q), ed));
    r    = clamp32(ed + ae);
    xrd  = clamp32(longint'($signed(s.target_velocity)) + ae);
    xrdd = clamp32(longint'($signed(s.target_accel)) + aed);
    u    = clamp32(qmul(xrdd, m_hat) + qmul(xrd, c_hat) + d_hat
                   + qmul(longint'(gain_k), r));
    m_hat = adapt(m_hat, xrdd, r, rate_m);
    c_hat = adapt(c_hat, xrd, r, rate_c);
    d_hat = adapt(d_hat, longint'(ONE_Q16), r, rate_d);
    t.drive          = u[DATA_W-1:0];
    t.filtered_error = r[DATA_W-1:0];
    t.mass_out       = m_hat[DATA_W-1:0];
    t.damping_out    = c_hat[DATA_W-1:0];
    t.offset_out     = d_hat[DATA_W-1:0];
    t.saturated      = clip_seen;
    return t;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ERROR_WEIGHT:  alpha_q = data[GAIN_W-1:0];
      REG_FEEDBACK_GAIN: gain_k  = data[GAIN_W-1:0];
      REG_MASS_RATE:     rate_m  = data[GAIN_W-1:0];
      REG_DAMPING_RATE:  rate_c  = data[GAIN_W-1:0];
      REG_OFFSET_RATE:   rate_d  = data[GAIN_W-1:0];
      REG_TIME_STEP:     dt_q    = data;
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] near(input int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // mostly a trajectory being tracked closely, now and then raw noise
  function automatic sample_t draw_sample();
    sample_t     s;
    int unsigned span;
    if ($urandom_range(0, 99) < 15) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      span = 1 << $urandom_range(4, 22);
      s.target_position = near(span);
      s.position        = s.target_position + near(1 << $urandom_range(0, 14));
      s.target_velocity = near(span);
      s.velocity        = s.target_velocity + near(1 << $urandom_range(0, 14));
      s.target_accel    = near(span << 2);
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tick %0d %s: got %08h, want %08h", ticks_seen, what, got, want);
    mismatches++;
  endtask

  // valid stays high across back-to-back transactions
  task automatic offer_sample(input sample_t s, input logic typed, input tick_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.position        <= s.position;
    sample_ch.velocity        <= s.velocity;
    sample_ch.target_position <= s.target_position;
    sample_ch.target_velocity <= s.target_velocity;
    sample_ch.target_accel    <= s.target_accel;
    do @(posedge clk); while (!sample_ch.ready);
    if (typed) begin
      void'(control_step(s));
      expected_ticks.insert(expected_ticks.size(), want);
    end else begin
      expected_ticks.insert(expected_ticks.size(), control_step(s));
    end
  endtask

  task automatic write_all_registers();
    for (int i = 0; i < 8; i++) begin
      write_enable <= 1'b1;
      write_index  <= WRITE_ORDER[i];
      write_data   <= pending_cfg[WRITE_ORDER[i]];
      @(posedge clk);
      apply_write(WRITE_ORDER[i], pending_cfg[WRITE_ORDER[i]]);
    end
    write_enable <= 1'b0;
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    tick_t got;
    tick_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = {result_ch.drive, result_ch.filtered_error, result_ch.mass_out,
             result_ch.damping_out, result_ch.offset_out, result_ch.saturated};
      if (expected_ticks.size() == 0) begin
        report_mismatch("result with none pending", got.drive, W_ZERO);
      end else begin
        want = expected_ticks.pop_front();
        if (got.drive !== want.drive)
          report_mismatch("drive", got.drive, want.drive);
        if (got.filtered_error !== want.filtered_error)
          report_mismatch("filtered_error", got.filtered_error, want.filtered_error);
        if (got.mass_out !== want.mass_out)
          report_mismatch("mass_out", got.mass_out, want.mass_out);
        if (got.damping_out !== want.damping_out)
          report_mismatch("damping_out", got.damping_out, want.damping_out);
        if (got.offset_out !== want.offset_out)
          report_mismatch("offset_out", got.offset_out, want.offset_out);
        if (got.saturated !== want.saturated)
          report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
      end
      ticks_seen++;
    end
  end

  initial begin
    int hold;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_request) begin
        // hold off long enough for the block to back up into its input
        stall_request = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          result_ch.ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin
    rst                       <= 1'b1;
    write_enable              <= 1'b0;
    write_index               <= REG_ERROR_WEIGHT;
    write_data                <= '0;
    sample_ch.valid           <= 1'b0;
    sample_ch.position        <= '0;
    sample_ch.velocity        <= '0;
    sample_ch.target_position <= '0;
    sample_ch.target_velocity <= '0;
    sample_ch.target_accel    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: foreach (pending_cfg[i]) pending_cfg[i] = 32'hFFFF_FFFF;
        1: foreach (pending_cfg[i]) pending_cfg[i] = 32'h0000_0000;
        2: begin
          pending_cfg[REG_ERROR_WEIGHT]  = 32'(ERROR_WEIGHT_RST);
          pending_cfg[REG_FEEDBACK_GAIN] = 32'(FEEDBACK_GAIN_RST);
          pending_cfg[REG_MASS_RATE]     = 32'(RATE_RST);
          pending_cfg[REG_DAMPING_RATE]  = 32'(RATE_RST);
          pending_cfg[REG_OFFSET_RATE]   = 32'(RATE_RST);
          pending_cfg[REG_TIME_STEP]     = TIME_STEP_RST;
          pending_cfg[UNMAPPED_LO]       = $urandom;
          pending_cfg[UNMAPPED_HI]       = $urandom;
        end
        default: begin
          // top bit set at random on the 31-bit gains: it must be dropped
          pending_cfg[REG_ERROR_WEIGHT]  = $urandom_range(0, 20 << 16)
                                           | ($urandom & 32'h8000_0000);
          pending_cfg[REG_FEEDBACK_GAIN] = $urandom_range(0, 40 << 16)
                                           | ($urandom & 32'h8000_0000);
          pending_cfg[REG_MASS_RATE]     = $urandom_range(0, 1 << 22)
                                           | ($urandom & 32'h8000_0000);
          pending_cfg[REG_DAMPING_RATE]  = $urandom_range(0, 1 << 22)
                                           | ($urandom & 32'h8000_0000);
          pending_cfg[REG_OFFSET_RATE]   = $urandom_range(0, 1 << 22)
                                           | ($urandom & 32'h8000_0000);
          pending_cfg[REG_TIME_STEP]     = $urandom_range(0, 1) ? $urandom
                                                                : $urandom_range(0, 1 << 26);
          pending_cfg[UNMAPPED_LO]       = $urandom;
          pending_cfg[UNMAPPED_HI]       = $urandom;
        end
      endcase
      write_all_registers();
      gaps_on = !(p == 2 || p == 5);
      if (p == 3) stall_request = 1'b1;
      repeat (RANDOM_PER_PHASE) offer_sample(draw_sample(), 1'b0, ZERO_TICK);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS adaptive_tracking_controller_unit");
    end else begin
      $display("FAIL adaptive_tracking_controller_unit");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL adaptive_tracking_controller_unit");
    $finish;
  end

endmodule

>>> adaptive_tracking_controller_unit.f
rtl/atc_pkg.sv
rtl/atc_if.sv
rtl/atc_alu.sv
rtl/adaptive_tracking_controller_unit.sv
rtl/atc_checker.sv
bench/tb_top.sv
